// ===== hdl/cwe_pkg.sv =====
// cwe_pkg: request/result types, opcodes and fixed constants of the
// cached weighted entropy block. No dependencies.
package cwe_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_QUERY       = 2'd1,
        OP_INVAL_CELL  = 2'd2,
        OP_INVAL_ALL   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic [3:0]  cell_z;
        logic [15:0] tile_mask;
        logic [3:0]  tile_index;
        logic [15:0] weight_value;
    } req_t;

    typedef struct packed {
        logic signed [23:0] entropy;
        logic               contradiction;
        logic               from_cache;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOKUP,
        ST_TILE,
        ST_LN_START,
        ST_SQ,
        ST_SQ_WAIT,
        ST_LN_MUL,
        ST_LN_WAIT,
        ST_T_MUL,
        ST_T_WAIT,
        ST_AFTER,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    localparam int MUL_W   = 32;
    localparam int DIVD_W  = 44;
    localparam int DIVS_W  = 20;
    localparam int LN_W    = 25;
    localparam int FRAC_N  = 20;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [23:0] ENT_NEG_ONE = 24'shFF0000;
    localparam logic signed [23:0] ENT_MAX     = 24'sh7FFFFF;

endpackage

// ===== hdl/cwe_if.sv =====
// cwe_req_if / cwe_res_if: valid/ready channels for requests and results.
// Depends on cwe_pkg.
interface cwe_req_if;
    logic          valid;
    logic          ready;
    cwe_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cwe_res_if;
    logic          valid;
    logic          ready;
    cwe_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cwe_mul.sv =====
// cwe_mul: shared unsigned multiplier with registered product.
// Depends on cwe_pkg.
module cwe_mul (
    input  logic                            clk,
    input  logic [cwe_pkg::MUL_W-1:0]       a,
    input  logic [cwe_pkg::MUL_W-1:0]       b,
    output logic [2*cwe_pkg::MUL_W-1:0]     prod
);
    import cwe_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

// ===== hdl/cwe_div.sv =====
// cwe_div: restoring divider, one quotient bit per cycle.
// Depends on cwe_pkg.
module cwe_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cwe_pkg::DIVD_W-1:0]   dividend,
    input  logic [cwe_pkg::DIVS_W-1:0]   divisor,
    output logic                         done,
    output logic [cwe_pkg::DIVD_W-1:0]   quotient
);
    import cwe_pkg::*;

    localparam int CW = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W:0]   rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W+1:0] trial;
    logic [DIVS_W+1:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIVD_W-1]};
        trial     = shifted - {2'b00, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVS_W+1])
            begin
                rem_next = trial[DIVS_W:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVS_W:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hdl/cached_weighted_entropy.sv =====
// Cached weighted entropy. One request is taken at a time; ready is high only
// while the block is idle. Load weight and invalidate cell pass through dispatch
// and return to idle; a query that hits the cache is answered from the cache read
// and then waits for the result handshake. A miss runs the sequencer over the
// shared 32x32 multiplier: skipped tiles are stepped over, each allowed nonzero
// tile is weighted by its log (20 squarings for the log), then ln(W) is taken
// and the serial divider is run. Invalidate all, and the period right after reset,
// sweep all GRID_X*GRID_Y*GRID_Z cells of the cache memory one cell per cycle, during which no request is accepted.
// Depends on cwe_pkg, cwe_if, cwe_mul, cwe_div.
module cached_weighted_entropy #(
    parameter int GRID_X    = 16,
    parameter int GRID_Y    = 16,
    parameter int GRID_Z    = 16,
    parameter int NUM_TILES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cwe_req_if.sink   req,
    cwe_res_if.source res
);
    import cwe_pkg::*;

    localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
    localparam int AW     = CELLS > 1 ? $clog2(CELLS) : 1;
    localparam int NT_EFF = NUM_TILES < 16 ? NUM_TILES : 16;
    localparam int TCW    = $clog2(NT_EFF + 1);
    localparam int TW     = NUM_TILES > 1 ? $clog2(NUM_TILES) : 1;

    state_t state_reg, state_next;
    req_t   rq_reg;
    res_t   out_reg, out_next;

    logic [15:0]      wtab_reg [NUM_TILES];
    logic [24:0]      cache_mem [CELLS];
    logic [24:0]      rd_reg;

    logic [AW-1:0]    clr_reg, clr_next;
    logic [TCW-1:0]   t_reg, t_next;
    logic [19:0]      u_reg, u_next;
    logic [30:0]      m_reg, m_next;
    logic [4:0]       p_reg, p_next;
    logic [FRAC_N-1:0] frac_reg, frac_next;
    logic [4:0]       k_reg, k_next;
    logic             lnw_reg, lnw_next;
    logic [LN_W-1:0]  ln_reg, ln_next;
    logic [19:0]      wsum_reg, wsum_next;
    logic [DIVD_W-1:0] tsum_reg, tsum_next;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  quo;

    logic              in_grid;
    logic [AW-1:0]     idx;
    logic [31:0]       idx_full;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [24:0]       mem_wdata;
    logic [15:0]       r_cur;
    logic [TW-1:0]     wi;
    logic [4:0]        p_enc;
    logic [31:0]       sq;
    logic [63:0]       ln_round;
    logic signed [26:0] h20;
    logic signed [26:0] hb;
    logic signed [22:0] ent_raw;
    logic signed [23:0] ent_clamped;

    cwe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

    cwe_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(tsum_reg), .divisor(wsum_reg),
        .done(div_done), .quotient(quo)
    );

    assign in_grid = (32'(rq_reg.cell_x) < 32'(GRID_X)) &&
                     (32'(rq_reg.cell_y) < 32'(GRID_Y)) &&
                     (32'(rq_reg.cell_z) < 32'(GRID_Z));
    assign idx_full = (32'(rq_reg.cell_x) * 32'(GRID_Y) + 32'(rq_reg.cell_y)) * 32'(GRID_Z)
                      + 32'(rq_reg.cell_z);
    assign idx = AW'(idx_full);

    assign wi    = TW'(t_reg);
    assign r_cur = wtab_reg[wi];

    // top set bit of the log argument
    always_comb
    begin
        p_enc = '0;
        for (int i = 0; i < 20; i++)
        begin
            if (u_reg[i])
            begin
                p_enc = 5'(i);
            end
        end
    end

    assign sq       = prod[61:30];
    assign ln_round = prod + 64'h8000_0000;

    // q.20 entropy, rounded to q.16 and clamped
    assign h20 = $signed({2'b00, ln_reg}) - $signed({2'b00, quo[LN_W-1:0]});
    assign hb  = h20 + 27'sd8;
    assign ent_raw = 23'(hb >>> 4);
    always_comb
    begin
        if (ent_raw < 0)
        begin
            ent_clamped = '0;
        end
        else if (24'(ent_raw) > ENT_MAX)
        begin
            ent_clamped = ENT_MAX;
        end
        else
        begin
            ent_clamped = 24'(ent_raw);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_next   = out_reg;
        clr_next   = clr_reg;
        t_next     = t_reg;
        u_next     = u_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        lnw_next   = lnw_reg;
        ln_next    = ln_reg;
        wsum_next  = wsum_reg;
        tsum_next  = tsum_reg;
        mul_a      = {1'b0, m_reg};
        mul_b      = {1'b0, m_reg};
        div_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx;
        mem_wdata  = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (opcode_t'(rq_reg.opcode))
                    OP_LOAD_WEIGHT: state_next = ST_IDLE;
                    OP_INVAL_CELL:
                    begin
                        mem_we     = in_grid;
                        state_next = ST_IDLE;
                    end
                    OP_INVAL_ALL:
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    OP_QUERY: state_next = ST_LOOKUP;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_LOOKUP:
            begin
                if (in_grid && rd_reg[24])
                begin
                    out_next.entropy       = rd_reg[23:0];
                    out_next.contradiction = 1'b0;
                    out_next.from_cache    = 1'b1;
                    state_next             = ST_OUT;
                end
                else
                begin
                    t_next     = '0;
                    wsum_next  = '0;
                    tsum_next  = '0;
                    lnw_next   = 1'b0;
                    state_next = ST_TILE;
                end
            end
            ST_TILE:
            begin
                if (t_reg == TCW'(NT_EFF))
                begin
                    state_next = ST_AFTER;
                end
                else if (rq_reg.tile_mask[4'(t_reg)] && r_cur != '0)
                begin
                    wsum_next  = wsum_reg + 20'(r_cur);
                    u_next     = 20'(r_cur);
                    state_next = ST_LN_START;
                end
                else
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            ST_LN_START:
            begin
                p_next     = p_enc;
                m_next     = 31'(u_reg) << (5'd30 - p_enc);
                frac_next  = '0;
                k_next     = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                mul_a      = {1'b0, m_reg};
                mul_b      = {1'b0, m_reg};
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                frac_next = {frac_reg[FRAC_N-2:0], sq[31]};
                m_next    = sq[31] ? sq[31:1] : sq[30:0];
                k_next    = k_reg + 1'b1;
                state_next = (k_reg == 5'(FRAC_N - 1)) ? ST_LN_MUL : ST_SQ;
            end
            ST_LN_MUL:
            begin
                mul_a      = 32'({p_reg, frac_reg});
                mul_b      = LN2_Q32;
                state_next = ST_LN_WAIT;
            end
            ST_LN_WAIT:
            begin
                ln_next = ln_round[32 +: LN_W];
                if (lnw_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    state_next = ST_T_MUL;
                end
            end
            ST_T_MUL:
            begin
                mul_a      = 32'(u_reg);
                mul_b      = 32'(ln_reg);
                state_next = ST_T_WAIT;
            end
            ST_T_WAIT:
            begin
                tsum_next  = tsum_reg + prod[DIVD_W-1:0];
                t_next     = t_reg + 1'b1;
                state_next = ST_TILE;
            end
            ST_AFTER:
            begin
                if (wsum_reg == '0)
                begin
                    out_next.entropy       = ENT_NEG_ONE;
                    out_next.contradiction = 1'b1;
                    out_next.from_cache    = 1'b0;
                    state_next             = ST_OUT;
                end
                else
                begin
                    u_next     = wsum_reg;
                    lnw_next   = 1'b1;
                    state_next = ST_LN_START;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    mem_we    = in_grid;
                    mem_wdata = {1'b1, ent_clamped};
                    out_next.entropy       = ent_clamped;
                    out_next.contradiction = 1'b0;
                    out_next.from_cache    = 1'b0;
                    state_next             = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < NUM_TILES; i++)
            begin
                wtab_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (state_reg == ST_DISPATCH &&
                opcode_t'(rq_reg.opcode) == OP_LOAD_WEIGHT &&
                32'(rq_reg.tile_index) < 32'(NUM_TILES))
            begin
                wtab_reg[TW'(rq_reg.tile_index)] <= rq_reg.weight_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            rq_reg <= req.data;
        end
        out_reg  <= out_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        m_reg    <= m_next;
        p_reg    <= p_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
        lnw_reg  <= lnw_next;
        ln_reg   <= ln_next;
        wsum_reg <= wsum_next;
        tsum_reg <= tsum_next;
    end

    // cache memory: valid bit on top of the q8.16 value
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cache_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= cache_mem[idx];
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_OUT);
    assign res.data  = out_reg;
endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for cached_weighted_entropy, driving requests and
// checking results against an in-bench entropy and cache predictor.
// Depends on cwe_pkg, cwe_if and the block itself.
`timescale 1ns / 100ps

module tb;
    import cwe_pkg::*;

    localparam int  N_RANDOM    = 1600;
    localparam int  CELL_COUNT  = 4096;
    localparam longint CYCLE_LIMIT = 12000000;

    logic clk = 1'b0;
    logic rst_n;

    cwe_req_if req_ch();
    cwe_res_if res_ch();

    cached_weighted_entropy uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // predictor state
    logic [15:0] weight_model [16];
    bit          cell_cached [CELL_COUNT];
    logic [23:0] cell_entropy [CELL_COUNT];

    req_t   request_q [$];
    res_t   expected_results [$];
    int     request_total;
    int     accepted_count = 0;
    int     error_count = 0;
    int     send_idle_pct = 24;
    int     recv_stall_pct = 57;
    longint cycle_count = 0;

    always #5 clk = ~clk;

    // natural log of u >= 1, Q.20
    function automatic longint unsigned ln_q20(input longint unsigned u);
        int unsigned       p;
        longint unsigned   m;
        longint unsigned   frac;
        p = 0;
        frac = 0;
        while (p < 40 && (u >> (p + 1)) != 0)
            p++;
        m = u << (30 - p);
        for (int k = 0; k < 20; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (((longint'(p) << 20) | frac) * 64'd2977044472 + (64'd1 << 31)) >> 32;
    endfunction

    function automatic void predict_request(input req_t rq);
        int              cell_id;
        longint unsigned wsum;
        longint unsigned tsum;
        longint          h20;
        longint          ent;
        res_t            r;
        cell_id = {rq.cell_x, rq.cell_y, rq.cell_z};
        wsum = 0;
        tsum = 0;
        case (opcode_t'(rq.opcode))
            OP_LOAD_WEIGHT: weight_model[rq.tile_index] = rq.weight_value;
            OP_INVAL_CELL:  cell_cached[cell_id] = 1'b0;
            OP_INVAL_ALL:   for (int c = 0; c < CELL_COUNT; c++) cell_cached[c] = 1'b0;
            default:
            begin
                if (cell_cached[cell_id])
                begin
                    r.entropy = cell_entropy[cell_id];
                    r.contradiction = 1'b0;
                    r.from_cache = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 16; i++)
                        if (rq.tile_mask[i] && weight_model[i] != 0)
                        begin
                            wsum += weight_model[i];
                            tsum += weight_model[i] * ln_q20(weight_model[i]);
                        end
                    if (wsum == 0)
                    begin
                        r.entropy = ENT_NEG_ONE;
                        r.contradiction = 1'b1;
                        r.from_cache = 1'b0;
                    end
                    else
                    begin
                        h20 = longint'(ln_q20(wsum)) - longint'(tsum / wsum);
                        ent = (h20 + 8) >>> 4;
                        if (ent < 0)
                            ent = 0;
                        if (ent > 64'h7FFFFF)
                            ent = 64'h7FFFFF;
                        r.entropy = ent[23:0];
                        r.contradiction = 1'b0;
                        r.from_cache = 1'b0;
                        cell_entropy[cell_id] = ent[23:0];
                        cell_cached[cell_id] = 1'b1;
                    end
                end
                expected_results.push_back(r);
            end
        endcase
    endfunction

    function automatic req_t make_request(input opcode_t op, input logic [11:0] cell_id,
                                          input logic [15:0] mask, input logic [3:0] tile,
                                          input logic [15:0] weight);
        req_t rq;
        rq.opcode = op;
        {rq.cell_x, rq.cell_y, rq.cell_z} = cell_id;
        rq.tile_mask = mask;
        rq.tile_index = tile;
        rq.weight_value = weight;
        return rq;
    endfunction

    function automatic logic [15:0] random_weight();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data <= request_q.pop_front();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // idle pattern follows progress through the request stream
    always @(posedge clk)
    begin
        if (accepted_count < request_total / 3)
        begin
            send_idle_pct <= 24;
            recv_stall_pct <= 57;
        end
        else if (accepted_count < 2 * request_total / 3)
        begin
            send_idle_pct <= 57;
            recv_stall_pct <= 24;
        end
        else
        begin
            send_idle_pct <= 0;
            recv_stall_pct <= 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_request(req_ch.data);
                accepted_count <= accepted_count + 1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result entropy=%h contradiction=%b from_cache=%b",
                             $time, res_ch.data.entropy, res_ch.data.contradiction,
                             res_ch.data.from_cache);
                    error_count++;
                end
                else
                begin
                    res_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (res_ch.data.entropy !== exp_r.entropy)
                    begin
                        $display("%0t: entropy expected %h actual %h", $time,
                                 exp_r.entropy, res_ch.data.entropy);
                        error_count++;
                    end
                    if (res_ch.data.contradiction !== exp_r.contradiction)
                    begin
                        $display("%0t: contradiction expected %b actual %b", $time,
                                 exp_r.contradiction, res_ch.data.contradiction);
                        error_count++;
                    end
                    if (res_ch.data.from_cache !== exp_r.from_cache)
                    begin
                        $display("%0t: from_cache expected %b actual %b", $time,
                                 exp_r.from_cache, res_ch.data.from_cache);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [11:0] recent_cells [8];
        logic [11:0] cell_id;
        int          pick;
        rst_n = 1'b0;
        for (int i = 0; i < 16; i++)
            weight_model[i] = '0;
        for (int c = 0; c < CELL_COUNT; c++)
            cell_cached[c] = 1'b0;

        // directed: contradiction on empty table, weight extremes, hit, invalidates
        request_q.push_back(make_request(OP_QUERY, 12'h000, 16'hFFFF, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_LOAD_WEIGHT, 12'h000, 16'h0000, 4'd0, 16'hFFFF));
        request_q.push_back(make_request(OP_LOAD_WEIGHT, 12'h000, 16'h0000, 4'd15, 16'd1));
        request_q.push_back(make_request(OP_LOAD_WEIGHT, 12'h000, 16'h0000, 4'd7, 16'h0100));
        request_q.push_back(make_request(OP_QUERY, 12'h000, 16'h0000, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'h001, 16'h0002, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'hFFF, 16'h0001, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'hFFF, 16'h0000, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'h123, 16'hFFFF, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'h456, 16'h8081, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'h123, 16'h0000, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_INVAL_CELL, 12'h123, 16'h0000, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'h123, 16'h8000, 4'd0, 16'd0));
        for (int i = 0; i < 16; i++)
            request_q.push_back(make_request(OP_LOAD_WEIGHT, 12'h000, 16'h0, 4'(i), 16'hFFFF));
        request_q.push_back(make_request(OP_QUERY, 12'hABC, 16'hFFFF, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_INVAL_ALL, 12'h000, 16'h0000, 4'd0, 16'd0));
        request_q.push_back(make_request(OP_QUERY, 12'hFFF, 16'h0001, 4'd0, 16'd0));

        for (int i = 0; i < 8; i++)
            recent_cells[i] = 12'($urandom);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            pick = $urandom_range(199);
            // reuse of recent cells gives cache hits and invalidate-then-miss
            if ($urandom_range(1))
                cell_id = recent_cells[$urandom_range(7)];
            else
            begin
                cell_id = 12'($urandom);
                recent_cells[$urandom_range(7)] = cell_id;
            end
            if (pick < 2)
                request_q.push_back(make_request(OP_INVAL_ALL, 12'($urandom),
                                    16'($urandom), 4'($urandom), 16'($urandom)));
            else if (pick < 50)
                request_q.push_back(make_request(OP_LOAD_WEIGHT, 12'($urandom),
                                    16'($urandom), 4'($urandom), random_weight()));
            else if (pick < 80)
                request_q.push_back(make_request(OP_INVAL_CELL, cell_id,
                                    16'($urandom), 4'($urandom), 16'($urandom)));
            else
                request_q.push_back(make_request(OP_QUERY, cell_id,
                                    ($urandom_range(9) == 0) ? 16'($urandom_range(1)) :
                                    16'($urandom), 4'($urandom), 16'($urandom)));
        end
        request_total = request_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_count == request_total);
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
